@@ sv/ksd_pkg.sv @@
// Shared types, constants and lookup tables for the keyboard scancode decoder.
// No dependencies; the decoder top level, the chord matcher and the checker use this package.
package ksd_pkg;

    // Held-key map and chord slot geometry
    localparam int KEY_CODES = 128;
    localparam int KEY_W = 7;
    localparam int SLOT_W = 3 * KEY_W;
    localparam int SLOTS_PER_REG = 3;
    localparam int CHORD_SLOTS_MAX = 10;
    localparam int CHORD_IDX_W = 4;
    localparam int CFG_DATA_W = SLOTS_PER_REG * SLOT_W;
    localparam int CFG_INDEX_W = 3;
    localparam int TABLE_LEN = 62;

    // Scancodes with special meaning
    localparam logic [7:0] SC_BACKSPACE = 8'h0E;
    localparam logic [7:0] SC_LSHIFT = 8'h2A;
    localparam logic [7:0] SC_RSHIFT = 8'h36;
    localparam logic [7:0] SC_ENTER = 8'h1C;
    localparam logic [6:0] ASCII_QMARK = 7'h3F;

    // Result action codes
    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_CHORD = 2'd1,
        ACT_BACKSPACE = 2'd2,
        ACT_CHAR = 2'd3
    } t_action;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHORD_COUNT = 3'd0,
        CFG_SPECIAL_ENTER = 3'd1,
        CFG_SLOTS_A = 3'd2,
        CFG_SLOTS_B = 3'd3,
        CFG_SLOTS_C = 3'd4,
        CFG_SLOTS_D = 3'd5
    } t_cfg_index;

    // Chord matcher result
    typedef struct packed {
        logic                   hit;
        logic [CHORD_IDX_W-1:0] index;
    } t_match;

    // Character tables, first character in the top byte
    localparam logic [TABLE_LEN*8-1:0] PLAIN_TAB =
        "??1234567890-=??qwertyuiop[]??asdfghjkl;'`?\\zxcvbnm,./??? ????";
    localparam logic [TABLE_LEN*8-1:0] SHIFT_TAB =
        "??!@#$%^&*()_+??QWERTYUIOP{}??ASDFGHJKL:\"~?|ZXCVBNM<>???? ????";

    // ASCII for a make code; codes past the tables give '?'
    function automatic logic [6:0] lookup_char(input logic [6:0] code, input logic shift);
        int pos;
        pos = TABLE_LEN - 1 - int'(code);
        if (int'(code) >= TABLE_LEN) begin
            return ASCII_QMARK;
        end
        if (shift) begin
            return SHIFT_TAB[pos*8 +: 7];
        end
        return PLAIN_TAB[pos*8 +: 7];
    endfunction

endpackage

@@ sv/ksd_scan_if.sv @@
// Scancode request channel: valid/ready handshake with one scancode byte.
// No dependencies.
interface ksd_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink (input valid, input scan_byte, output ready);
endinterface

@@ sv/ksd_result_if.sv @@
// Result request channel: valid/ready handshake with action, chord index and character.
// No dependencies.
interface ksd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [3:0] chord_index;
    logic [6:0] character;

    modport source (output valid, output action, output chord_index, output character,
                    input ready);
    modport sink (input valid, input action, input chord_index, input character,
                  output ready);
endinterface

@@ sv/keyboard_scancode_decoder.sv @@
// Top level of the set-1 scancode decoder: held-key map, chord check, ASCII decode.
// Depends on ksd_pkg, ksd_scan_if, ksd_result_if and ksd_chord_match.
//
//  channel    dir  handshake       payload
//  i_scan     in   valid/ready     scan_byte[7:0]
//  o_result   out  valid/ready     action[1:0], chord_index[3:0], character[6:0]
//  i_cfg_*    in   write enable    i_cfg_index[2:0], i_cfg_data[62:0]
//
// One scancode per cycle while the output is not stalled; a result passes stage one, then the output register.
// Stage one updates the held-key map, stage two checks chords and decodes into the
// output register. A stalled output holds stage two, and stage one fills behind it
// before the input stalls. Synchronous active-low reset clears the map, the config
// registers and the pipeline valid bits.
module keyboard_scancode_decoder #(
    parameter int CHORD_SLOTS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ksd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [ksd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ksd_scan_if.sink                          i_scan,
    ksd_result_if.source                      o_result
);

    // Configuration registers
    logic [3:0]                 r_chord_count;
    logic                       r_special_enter;
    logic [ksd_pkg::SLOT_W-1:0] r_slots [CHORD_SLOTS];

    // Pipeline state
    logic [ksd_pkg::KEY_CODES-1:0] r_key_map, n_key_map;
    logic                          r_s1_valid;
    logic [7:0]                    r_s1_code;
    logic                          r_out_valid;
    ksd_pkg::t_action              r_action, n_action;
    logic [3:0]                    r_chord_index, n_chord_index;
    logic [6:0]                    r_character, n_character;

    logic            s1_go;
    logic            in_accept;
    logic            shift_held;
    ksd_pkg::t_match match;

    assign s1_go = !r_out_valid || o_result.ready;
    assign i_scan.ready = !r_s1_valid || s1_go;
    assign in_accept = i_scan.valid && i_scan.ready;

    // Config writes; slot s sits in slot register s/3 at group s%3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chord_count <= '0;
            r_special_enter <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ksd_pkg::CFG_CHORD_COUNT:   r_chord_count <= i_cfg_data[3:0];
                ksd_pkg::CFG_SPECIAL_ENTER: r_special_enter <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    for (genvar s = 0; s < CHORD_SLOTS; s++) begin : g_slot_reg
        localparam int RegSel = s / ksd_pkg::SLOTS_PER_REG;
        localparam int SubSel = s % ksd_pkg::SLOTS_PER_REG;
        localparam logic [ksd_pkg::CFG_INDEX_W-1:0] SlotIdx =
            ksd_pkg::CFG_INDEX_W'(int'(ksd_pkg::CFG_SLOTS_A) + RegSel);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_slots[s] <= '0;
            end else if (i_cfg_we && i_cfg_index == SlotIdx) begin
                r_slots[s] <= i_cfg_data[SubSel*ksd_pkg::SLOT_W +: ksd_pkg::SLOT_W];
            end
        end
    end

    // Stage one: make sets, break clears, 0x80 leaves the map alone
    always_comb begin
        n_key_map = r_key_map;
        if (!i_scan.scan_byte[7]) begin
            n_key_map[i_scan.scan_byte[6:0]] = 1'b1;
        end else if (i_scan.scan_byte[6:0] != 7'd0) begin
            n_key_map[i_scan.scan_byte[6:0]] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_map <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_key_map <= n_key_map;
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_code <= i_scan.scan_byte;
        end
    end

    // Stage two: chord check on the updated map
    ksd_chord_match #(
        .CHORD_SLOTS (CHORD_SLOTS)
    ) u_chord_match (
        .i_key_map     (r_key_map),
        .i_slots       (r_slots),
        .i_chord_count (r_chord_count),
        .o_match       (match)
    );

    assign shift_held = r_key_map[ksd_pkg::SC_LSHIFT[6:0]] || r_key_map[ksd_pkg::SC_RSHIFT[6:0]];

    // Chord hit first, then make-code decode; break codes give nothing
    always_comb begin
        n_action = ksd_pkg::ACT_NONE;
        n_chord_index = '0;
        n_character = '0;
        if (match.hit) begin
            n_action = ksd_pkg::ACT_CHORD;
            n_chord_index = match.index;
        end else if (!r_s1_code[7]) begin
            if (r_s1_code == ksd_pkg::SC_BACKSPACE) begin
                n_action = ksd_pkg::ACT_BACKSPACE;
            end else if (r_s1_code inside {ksd_pkg::SC_LSHIFT, ksd_pkg::SC_RSHIFT}) begin
                n_action = ksd_pkg::ACT_NONE;
            end else if (r_s1_code == ksd_pkg::SC_ENTER && r_special_enter) begin
                n_action = ksd_pkg::ACT_CHAR;
                n_character = ksd_pkg::SC_ENTER[6:0];
            end else begin
                n_action = ksd_pkg::ACT_CHAR;
                n_character = ksd_pkg::lookup_char(r_s1_code[6:0], shift_held);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_valid) begin
            r_action <= n_action;
            r_chord_index <= n_chord_index;
            r_character <= n_character;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.action = r_action;
    assign o_result.chord_index = r_chord_index;
    assign o_result.character = r_character;

endmodule

@@ sv/ksd_chord_match.sv @@
// Chord matcher: tests every active chord slot against the held-key map, first hit wins.
// Depends on ksd_pkg.
module ksd_chord_match #(
    parameter int CHORD_SLOTS = 10
) (
    input  logic [ksd_pkg::KEY_CODES-1:0] i_key_map,
    input  logic [ksd_pkg::SLOT_W-1:0]    i_slots [CHORD_SLOTS],
    input  logic [3:0]                    i_chord_count,
    output ksd_pkg::t_match               o_match
);

    logic [CHORD_SLOTS-1:0] hit;

    // Per-slot test; a zero second or third key counts as held.
    // Slots at or past the count are off, which also caps the count at CHORD_SLOTS.
    for (genvar s = 0; s < CHORD_SLOTS; s++) begin : g_slot
        logic [ksd_pkg::KEY_W-1:0] k1, k2, k3;
        assign k1 = i_slots[s][0 +: ksd_pkg::KEY_W];
        assign k2 = i_slots[s][ksd_pkg::KEY_W +: ksd_pkg::KEY_W];
        assign k3 = i_slots[s][2*ksd_pkg::KEY_W +: ksd_pkg::KEY_W];
        assign hit[s] = (4'(s) < i_chord_count) && i_key_map[k1]
                        && ((k2 == '0) || i_key_map[k2])
                        && ((k3 == '0) || i_key_map[k3]);
    end

    // Lowest-numbered hit
    always_comb begin
        o_match = '0;
        for (int s = CHORD_SLOTS - 1; s >= 0; s--) begin
            if (hit[s]) begin
                o_match.hit = 1'b1;
                o_match.index = ksd_pkg::CHORD_IDX_W'(s);
            end
        end
    end

endmodule

@@ sv/ksd_checker.sv @@
// Port-level checks for the scancode decoder, bound to the top level.
// Depends on ksd_pkg and keyboard_scancode_decoder.
module ksd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [1:0] i_action,
    input logic [3:0] i_chord_index,
    input logic [6:0] i_character
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // Chord index only carries meaning on a chord hit
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_action != ksd_pkg::ACT_CHORD) |-> i_chord_index == 4'd0)
        else $error("chord index set without a chord hit");

    // Character only carries meaning on a character action
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_action != ksd_pkg::ACT_CHAR) |-> i_character == 7'd0)
        else $error("character set without a character action");

    // A stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_action)
            && $stable(i_chord_index) && $stable(i_character)))
        else $error("stalled result changed");

endmodule

bind keyboard_scancode_decoder ksd_checker u_ksd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_result.valid),
    .i_res_ready   (o_result.ready),
    .i_action      (o_result.action),
    .i_chord_index (o_result.chord_index),
    .i_character   (o_result.character)
);
